// ===== rtl/first_fit_heap_allocator_defines.svh =====
// Assertion macros for the first-fit heap allocator.
// Included by first_fit_heap_allocator, which carries concurrent assertions; no dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is asserted.
`define FFHA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ffha assertion failed");
// Checked property, evaluated during reset as well.
`define FFHA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("ffha assertion failed");
`else
`define FFHA_ASSERT(lbl, prop)
`define FFHA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/ffha_pkg.sv =====
// Shared types and codes of the first-fit heap allocator.
// No dependencies; used by ffha_table and first_fit_heap_allocator.
`default_nettype none
package ffha_pkg;

    localparam int SIZE_W = 20;
    localparam int OFF_W  = 21;
    localparam int CNT_W  = 7;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    // One table entry: used mark and payload size.
    typedef struct packed {
        logic              used;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // Write request into the block table.
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] idx;
        entry_t           data;
    } tbl_wr_t;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] request_size;
        logic [OFF_W-1:0]  free_offset;
    } in_word_t;

    typedef struct packed {
        logic [OFF_W-1:0] payload_offset;
        logic [1:0]       status;
        logic [CNT_W-1:0] block_count;
    } out_word_t;

endpackage
`default_nettype wire

// ===== rtl/ffha_table.sv =====
// Block table memory: one write port, one registered read port.
// Depends on ffha_pkg. Entry zero reads as the whole heap until first written.
`default_nettype none
module ffha_table
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int HEAP_BYTES = 1048576,
    parameter int HDR_BYTES  = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tbl_wr_t          wr,
    input  wire logic [CNT_W-1:0] rd_idx,
    output entry_t                rd_data
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [SIZE_W-1:0] FIRST_SIZE = SIZE_W'(HEAP_BYTES - HDR_BYTES);

    entry_t mem [MAX_BLOCKS];
    entry_t rd_reg;
    logic   init0_reg;
    logic   dflt_reg;

    // Memory array with read-before-write behavior.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx[AW-1:0]] <= wr.data;
        end
        rd_reg <= mem[rd_idx[AW-1:0]];
    end

    // Track whether entry zero still holds its reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init0_reg <= 1'b0;
            dflt_reg  <= 1'b0;
        end
        else
        begin
            dflt_reg <= (rd_idx == '0) && !init0_reg;
            if (wr.en && (wr.idx == '0))
            begin
                init0_reg <= 1'b1;
            end
        end
    end

    assign rd_data = dflt_reg ? '{used: 1'b0, size: FIRST_SIZE} : rd_reg;

endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator: an address-ordered block table in a memory.
// Channel req takes an allocate or free word and channel rsp returns one
// result word per request: payload offset, status and block count.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The block handles one request at a time: req_stall is high from
// the accept until the result has been loaded into the output register.
// The table is walked one entry a cycle through the memory read port, then a
// split shifts later entries up or a merge shifts them down, one entry a
// cycle on the single write port. A zero-size allocate skips the walk and
// goes straight to the result; a scan stops where the moves begin.
// The output register holds its word while rsp_stall is high; a new request
// is accepted meanwhile, but its result waits for the register to empty.
// After reset the table holds one free block covering the whole heap; no
// clearing pass is needed.
// Depends on ffha_pkg, ffha_table and first_fit_heap_allocator_defines.svh.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = 1048576,
    parameter int HDR_BYTES  = 32,
    parameter int MAX_BLOCKS = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire in_word_t  req_word,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output out_word_t      rsp_word
);

    localparam int HW = 22;
    localparam logic [HW-1:0]    HDR_X = HW'(HDR_BYTES);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BLOCKS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_NEXT = 3'd2;
    localparam logic [2:0] S_SHUP = 3'd3;
    localparam logic [2:0] S_SHDN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rdv_reg, rdv_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    logic              mode_reg, mode_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [HW-1:0]     hdr_reg, hdr_next;
    entry_t            prev_reg, prev_next;
    logic              pfree_reg, pfree_next;
    logic [SIZE_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  sp_reg, sp_next;
    logic [CNT_W-1:0]  wp_reg, wp_next;
    logic [1:0]        k_reg, k_next;
    logic [SIZE_W-1:0] ins_reg, ins_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic [1:0]        res_st_reg, res_st_next;

    tbl_wr_t           wr;
    logic [CNT_W-1:0]  rd_idx;
    entry_t            rd;

    logic [HW-1:0]     hdr_pay;
    logic [HW-1:0]     need;
    logic [HW-1:0]     merged;
    logic              nfree;

    ffha_table #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .HEAP_BYTES (HEAP_BYTES),
        .HDR_BYTES  (HDR_BYTES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_idx  (rd_idx),
        .rd_data (rd)
    );

    assign hdr_pay = hdr_reg + HDR_X;
    assign need    = {2'b00, req_reg} + HDR_X;
    assign nfree   = ((idx_reg + 7'd1) < count_reg) && !rd.used;

    // Sequencer: scan, neighbor check, and shift sweeps over the table.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rdv_next       = rdv_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        mode_next      = mode_reg;
        req_next       = req_reg;
        off_next       = off_reg;
        i_next         = i_reg;
        hdr_next       = hdr_reg;
        prev_next      = prev_reg;
        pfree_next     = pfree_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        sp_next        = sp_reg;
        wp_next        = wp_reg;
        k_next         = k_reg;
        ins_next       = ins_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        wr             = '0;
        rd_idx         = '0;
        merged         = '0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next    = req_word.mode;
                    req_next     = req_word.request_size;
                    off_next     = req_word.free_offset;
                    i_next       = '0;
                    hdr_next     = '0;
                    res_off_next = '0;
                    if ((req_word.mode == MODE_ALLOC) && (req_word.request_size == '0))
                    begin
                        res_st_next = ST_ZERO;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Entry i is on the read port; prefetch entry i+1.
                rd_idx = i_reg + 7'd1;
                if (i_reg >= count_reg)
                begin
                    res_st_next = (mode_reg == MODE_ALLOC) ? ST_OOM : ST_BADFREE;
                    state_next  = S_DONE;
                end
                else if (mode_reg == MODE_ALLOC)
                begin
                    if (!rd.used && ((rd.size == req_reg) || ({2'b00, rd.size} >= need)))
                    begin
                        wr.en        = 1'b1;
                        wr.idx       = i_reg;
                        wr.data.used = 1'b1;
                        res_off_next = hdr_pay[OFF_W-1:0];
                        res_st_next  = ST_OK;
                        if (({2'b00, rd.size} > need) && (count_reg < MAX_C))
                        begin
                            wr.data.size = req_reg;
                            ins_next     = SIZE_W'({2'b00, rd.size} - need);
                            idx_next     = i_reg;
                            sp_next      = count_reg - 7'd1;
                            rdv_next     = 1'b0;
                            state_next   = S_SHUP;
                        end
                        else
                        begin
                            wr.data.size = rd.size;
                            state_next   = S_DONE;
                        end
                    end
                    else
                    begin
                        hdr_next = hdr_pay + {2'b00, rd.size};
                        i_next   = i_reg + 7'd1;
                    end
                end
                else
                begin
                    if (hdr_pay == {1'b0, off_reg})
                    begin
                        if (rd.used)
                        begin
                            idx_next   = i_reg;
                            cur_next   = rd.size;
                            pfree_next = (i_reg != '0) && !prev_reg.used;
                            state_next = S_NEXT;
                        end
                        else
                        begin
                            res_st_next = ST_BADFREE;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        prev_next = rd;
                        hdr_next  = hdr_pay + {2'b00, rd.size};
                        i_next    = i_reg + 7'd1;
                    end
                end
            end
            S_NEXT:
            begin
                // Entry idx+1 is on the read port; merge with free neighbors.
                res_off_next = '0;
                res_st_next  = ST_OK;
                wr.en        = 1'b1;
                wr.data.used = 1'b0;
                rdv_next     = 1'b0;
                if (pfree_reg && nfree)
                begin
                    merged       = {2'b00, prev_reg.size} + {2'b00, cur_reg}
                                   + {2'b00, rd.size} + HDR_X + HDR_X;
                    wr.idx       = idx_reg - 7'd1;
                    wr.data.size = merged[SIZE_W-1:0];
                    k_next       = 2'd2;
                    sp_next      = idx_reg + 7'd2;
                    state_next   = S_SHDN;
                end
                else if (pfree_reg)
                begin
                    merged       = {2'b00, prev_reg.size} + {2'b00, cur_reg} + HDR_X;
                    wr.idx       = idx_reg - 7'd1;
                    wr.data.size = merged[SIZE_W-1:0];
                    k_next       = 2'd1;
                    sp_next      = idx_reg + 7'd1;
                    state_next   = S_SHDN;
                end
                else if (nfree)
                begin
                    merged       = {2'b00, cur_reg} + {2'b00, rd.size} + HDR_X;
                    wr.idx       = idx_reg;
                    wr.data.size = merged[SIZE_W-1:0];
                    k_next       = 2'd1;
                    sp_next      = idx_reg + 7'd2;
                    state_next   = S_SHDN;
                end
                else
                begin
                    wr.idx       = idx_reg;
                    wr.data.size = cur_reg;
                    state_next   = S_DONE;
                end
            end
            S_SHUP:
            begin
                // Move entries up by one, top first, then write the remainder.
                if (rdv_reg)
                begin
                    wr.en   = 1'b1;
                    wr.idx  = wp_reg + 7'd1;
                    wr.data = rd;
                end
                if (sp_reg > idx_reg)
                begin
                    rd_idx   = sp_reg;
                    wp_next  = sp_reg;
                    rdv_next = 1'b1;
                    sp_next  = sp_reg - 7'd1;
                end
                else
                begin
                    rdv_next = 1'b0;
                    if (!rdv_reg)
                    begin
                        wr.en        = 1'b1;
                        wr.idx       = idx_reg + 7'd1;
                        wr.data.used = 1'b0;
                        wr.data.size = ins_reg;
                        count_next   = count_reg + 7'd1;
                        state_next   = S_DONE;
                    end
                end
            end
            S_SHDN:
            begin
                // Move entries down by k, bottom first.
                if (rdv_reg)
                begin
                    wr.en   = 1'b1;
                    wr.idx  = wp_reg - {5'd0, k_reg};
                    wr.data = rd;
                end
                if (sp_reg < count_reg)
                begin
                    rd_idx   = sp_reg;
                    wp_next  = sp_reg;
                    rdv_next = 1'b1;
                    sp_next  = sp_reg + 7'd1;
                end
                else
                begin
                    rdv_next = 1'b0;
                    if (!rdv_reg)
                    begin
                        count_next = count_reg - {5'd0, k_reg};
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.payload_offset = res_off_reg;
                    out_word_next.status         = res_st_reg;
                    out_word_next.block_count    = count_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 7'd1;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        mode_reg     <= mode_next;
        req_reg      <= req_next;
        off_reg      <= off_next;
        i_reg        <= i_next;
        hdr_reg      <= hdr_next;
        prev_reg     <= prev_next;
        pfree_reg    <= pfree_next;
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        sp_reg       <= sp_next;
        wp_reg       <= wp_next;
        k_reg        <= k_next;
        ins_reg      <= ins_next;
        res_off_reg  <= res_off_next;
        res_st_reg   <= res_st_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    // The block count stays between one and the table depth.
    `FFHA_ASSERT(a_count_range, (count_reg != '0) && (count_reg <= MAX_C))
    // An accepted word blocks the request channel on the next cycle.
    `FFHA_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall)
    // Every failed request reports a zero offset.
    `FFHA_ASSERT(a_fail_zero_off,
        (rsp_valid && (rsp_word.status != ST_OK)) |-> (rsp_word.payload_offset == '0))
    // A split never grows the table past its depth.
    `FFHA_ASSERT(a_split_room, (state_reg == S_SHUP) |-> (count_reg < MAX_C))

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the first-fit heap allocator: directed table, table fill, then random mix.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
module tb_top;
    import ffha_pkg::*;

    localparam int HEAP  = 1048576;
    localparam int HDR   = 32;
    localparam int NBLK  = 64;
    localparam int N_RAND = 1000;
    localparam int CYCLE_LIMIT = 2000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_word_t  req_word = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    out_word_t rsp_word;

    first_fit_heap_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_word (req_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word (rsp_word)
    );

    always #6 clk = ~clk;

    // Shadow copy of the block table.
    logic [SIZE_W-1:0] blk_size [NBLK];
    logic              heap_used [NBLK];
    int                heap_count;

    out_word_t expected_words [$];
    int        errors;
    int        cycles;
    int        words_seen;
    bit        hold_rsp;
    bit        no_idle;
    int        n_alloc_ok, n_free_ok, n_oom, n_bad;

    // Directed rows; chk marks a row whose result is typed in.
    typedef struct {
        in_word_t  w;
        bit        chk;
        out_word_t r;
    } dir_row_t;

    function automatic in_word_t mk_alloc(int sz);
        in_word_t w;
        w = '0;
        w.mode = MODE_ALLOC;
        w.request_size = sz[SIZE_W-1:0];
        w.free_offset = OFF_W'($urandom);
        return w;
    endfunction

    function automatic in_word_t mk_free(int off);
        in_word_t w;
        w = '0;
        w.mode = MODE_FREE;
        w.request_size = SIZE_W'($urandom);
        w.free_offset = off[OFF_W-1:0];
        return w;
    endfunction

    task automatic heap_reset();
        for (int i = 0; i < NBLK; i++)
        begin
            blk_size[i] = '0;
            heap_used[i] = 1'b0;
        end
        blk_size[0] = SIZE_W'(HEAP - HDR);
        heap_count = 1;
    endtask

    function automatic void drop_block(int idx);
        for (int j = idx; j + 1 < heap_count; j++)
        begin
            blk_size[j] = blk_size[j+1];
            heap_used[j] = heap_used[j+1];
        end
        heap_count--;
        blk_size[heap_count] = '0;
        heap_used[heap_count] = 1'b0;
    endfunction

    // Predict the result of one word and update the shadow table.
    function automatic out_word_t predict_heap(in_word_t w);
        out_word_t r;
        longint hdr_at;
        longint sz;
        longint req;
        int idx;
        r = '0;
        r.status = ST_OK;
        hdr_at = 0;
        if (w.mode == MODE_ALLOC)
        begin
            req = w.request_size;
            if (req == 0)
                r.status = ST_ZERO;
            else
            begin
                r.status = ST_OOM;
                for (int i = 0; i < heap_count; i++)
                begin
                    sz = blk_size[i];
                    if (!heap_used[i] && (sz == req || sz >= req + HDR))
                    begin
                        if (sz != req && sz - req > HDR && heap_count < NBLK)
                        begin
                            for (int j = heap_count; j > i + 1; j--)
                            begin
                                blk_size[j] = blk_size[j-1];
                                heap_used[j] = heap_used[j-1];
                            end
                            blk_size[i] = SIZE_W'(req);
                            blk_size[i+1] = SIZE_W'(sz - req - HDR);
                            heap_used[i+1] = 1'b0;
                            heap_count++;
                        end
                        heap_used[i] = 1'b1;
                        r.status = ST_OK;
                        r.payload_offset = OFF_W'(hdr_at + HDR);
                        break;
                    end
                    hdr_at += HDR + sz;
                end
            end
        end
        else
        begin
            idx = -1;
            for (int i = 0; i < heap_count; i++)
            begin
                if (hdr_at + HDR == longint'(w.free_offset))
                begin
                    idx = i;
                    break;
                end
                hdr_at += HDR + blk_size[i];
            end
            if (idx < 0 || !heap_used[idx])
                r.status = ST_BADFREE;
            else
            begin
                heap_used[idx] = 1'b0;
                if (idx > 0 && !heap_used[idx-1])
                begin
                    blk_size[idx-1] = blk_size[idx-1] + blk_size[idx] + SIZE_W'(HDR);
                    drop_block(idx);
                    idx--;
                end
                if (idx + 1 < heap_count && !heap_used[idx+1])
                begin
                    blk_size[idx] = blk_size[idx] + blk_size[idx+1] + SIZE_W'(HDR);
                    drop_block(idx + 1);
                end
            end
        end
        r.block_count = CNT_W'(heap_count);
        return r;
    endfunction

    // Payload offset of a random used block, or -1 if none.
    function automatic int pick_used_offset();
        int offs [$];
        int at;
        at = 0;
        for (int i = 0; i < heap_count; i++)
        begin
            if (heap_used[i])
                offs.push_back(at + HDR);
            at += HDR + blk_size[i];
        end
        if (offs.size() == 0)
            return -1;
        return offs[$urandom_range(offs.size() - 1)];
    endfunction

    // Send one word: idle at random, hold it until accepted, then predict and queue its result.
    task automatic send_word(in_word_t w, bit chk, out_word_t r);
        out_word_t p;
        while (!no_idle && $urandom_range(99) < 36)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_word  <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        p = predict_heap(w);
        if (chk && p != r)
        begin
            $error("directed row predicted %h, table says %h", p, r);
            errors++;
        end
        expected_words.push_back(p);
        if (p.status == ST_OK)
        begin
            if (w.mode == MODE_ALLOC)
                n_alloc_ok++;
            else
                n_free_ok++;
        end
        else if (p.status == ST_OOM)
            n_oom++;
        else if (p.status == ST_BADFREE)
            n_bad++;
        @(negedge clk);
    endtask

    // Stop offering words and wait until every expected result has come.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    // Receiver stall pattern, with one long hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_rsp)
            rsp_stall <= 1'b1;
        else if (no_idle)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < 36);
    end

    // Compare each accepted result word with the oldest expected one.
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            words_seen++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", rsp_word);
                errors++;
            end
            else
            begin
                out_word_t e;
                e = expected_words.pop_front();
                if (rsp_word.payload_offset != e.payload_offset)
                begin
                    $error("payload_offset: expected %0d, actual %0d",
                           e.payload_offset, rsp_word.payload_offset);
                    errors++;
                end
                if (rsp_word.status != e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, rsp_word.status);
                    errors++;
                end
                if (rsp_word.block_count != e.block_count)
                begin
                    $error("block_count: expected %0d, actual %0d",
                           e.block_count, rsp_word.block_count);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("first_fit_heap_allocator: mismatch");
            $finish;
        end
    end

    function automatic out_word_t res(int off, logic [1:0] st, int cnt);
        out_word_t r;
        r.payload_offset = off[OFF_W-1:0];
        r.status = st;
        r.block_count = cnt[CNT_W-1:0];
        return r;
    endfunction

    initial
    begin
        dir_row_t rows [$];
        out_word_t none;
        int off;
        int sz;
        int pick;
        errors = 0;
        cycles = 0;
        words_seen = 0;
        hold_rsp = 1'b0;
        no_idle = 1'b0;
        none = '0;
        heap_reset();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows: zero size, bad frees, extremes, split, exact fit, coalescing.
        rows.push_back('{mk_alloc(0), 1, res(0, ST_ZERO, 1)});
        rows.push_back('{mk_free(HDR), 1, res(0, ST_BADFREE, 1)});
        rows.push_back('{mk_free(HEAP), 1, res(0, ST_BADFREE, 1)});
        rows.push_back('{mk_alloc(1048544), 1, res(HDR, ST_OK, 1)});
        rows.push_back('{mk_alloc(1), 1, res(0, ST_OOM, 1)});
        rows.push_back('{mk_free(HDR), 1, res(0, ST_OK, 1)});
        rows.push_back('{mk_free(HDR), 1, res(0, ST_BADFREE, 1)});
        rows.push_back('{mk_alloc(100), 1, res(HDR, ST_OK, 2)});
        rows.push_back('{mk_alloc(200), 1, res(164, ST_OK, 3)});
        rows.push_back('{mk_alloc(300), 1, res(396, ST_OK, 4)});
        rows.push_back('{mk_free(164), 0, none});
        rows.push_back('{mk_alloc(200), 0, none});
        rows.push_back('{mk_free(164), 0, none});
        rows.push_back('{mk_alloc(180), 0, none});
        rows.push_back('{mk_free(HDR), 0, none});
        rows.push_back('{mk_free(396), 0, none});
        rows.push_back('{mk_free(164), 0, none});
        rows.push_back('{mk_alloc(1048543), 0, none});
        rows.push_back('{mk_alloc(1048577 - 2 * HDR), 0, none});
        rows.push_back('{mk_free(2097151), 0, none});
        rows.push_back('{mk_alloc(1048575), 0, none});
        foreach (rows[i])
            send_word(rows[i].w, rows[i].chk, rows[i].r);

        // Fill the table so the full-table path is hit, then free it all.
        while (heap_count < NBLK)
            send_word(mk_alloc($urandom_range(1, 64)), 0, none);
        send_word(mk_alloc(200), 0, none);
        send_word(mk_alloc(HEAP), 0, none);
        wait_drained();
        off = pick_used_offset();
        while (off >= 0)
        begin
            send_word(mk_free(off), 0, none);
            off = pick_used_offset();
        end

        // Random traffic: mostly valid frees and small allocations.
        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == 300)
                no_idle = 1'b1;
            if (n == 420)
                no_idle = 1'b0;
            if (n == 500)
            begin
                // Sender pauses until everything has come back.
                wait_drained();
            end
            if (n == 600)
                fork
                    begin
                        hold_rsp = 1'b1;
                        repeat (400) @(negedge clk);
                        hold_rsp = 1'b0;
                    end
                join_none
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                off = pick_used_offset();
                if (off < 0)
                    off = $urandom_range(HEAP);
                send_word(mk_free(off), 0, none);
            end
            else if (pick < 47)
                send_word(mk_free($urandom_range(2097151)), 0, none);
            else if (pick < 50)
                send_word(mk_alloc(0), 0, none);
            else if (pick < 55)
                send_word(mk_alloc($urandom_range(1048575)), 0, none);
            else
            begin
                sz = ($urandom_range(3) == 0) ? $urandom_range(1, 60000)
                                               : $urandom_range(1, 2000);
                send_word(mk_alloc(sz), 0, none);
            end
        end

        wait_drained();
        repeat (200) @(negedge clk);
        $display("Covered %0d result words: %0d grants, %0d releases, %0d out-of-memory,",
                 words_seen, n_alloc_ok, n_free_ok, n_oom);
        $display("%0d bad releases, with a long output hold-off and a drain pause.", n_bad);
        if (errors == 0 && expected_words.size() == 0)
            $display("first_fit_heap_allocator: match");
        else
            $display("first_fit_heap_allocator: mismatch");
        $finish;
    end
endmodule
